/* rtl/quadratic_contour_to_cubic_path_assert.svh */
// assertion macros for the rtl
`ifndef QUADRATIC_CONTOUR_TO_CUBIC_PATH_ASSERT_SVH
`define QUADRATIC_CONTOUR_TO_CUBIC_PATH_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QC2C_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qc2c assertion failed");
// next-cycle implication
`define QC2C_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qc2c assertion failed");
`else
`define QC2C_ASSERT_IMP(name, clk, rstn, ante, cons)
`define QC2C_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* rtl/qc2c_pkg.sv */
`default_nettype none
package qc2c_pkg;

    // result words per point, at most
    localparam int SLOTS      = 3;
    localparam int SLOT_IDX_W = 2;

    // n / 3 == (n * DIV3_MAGIC) >> DIV3_SHIFT for 0 <= n < 2**19
    localparam logic [18:0] DIV3_MAGIC = 19'd349526;
    localparam int          DIV3_SHIFT = 20;

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_CURVE = 2'd2,
        CMD_FILL  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               on_curve;
        logic               contour_end;
        logic               glyph_end;
    } point_t;

    // result word before the divide by three: n1 = 2c+s, n2 = e+2c
    typedef struct packed {
        cmd_t               cmd;
        logic signed [17:0] n1x;
        logic signed [17:0] n1y;
        logic signed [17:0] n2x;
        logic signed [17:0] n2y;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic               last;
    } raw_t;

    // (a + b) / 2 truncated toward zero
    function automatic logic signed [15:0] mid2(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        logic [16:0] s;
        logic [16:0] t;
        s = {a[15], a} + {b[15], b};
        t = s + {16'd0, s[16]};
        return t[16:1];
    endfunction

    // 2c + s
    function automatic logic signed [17:0] twice_plus(input logic signed [15:0] c,
                                                      input logic signed [15:0] s);
        return {c[15], c, 1'b0} + {{2{s[15]}}, s};
    endfunction

    // n / 3 truncated toward zero, |n| <= 98304
    function automatic logic signed [15:0] div3(input logic signed [17:0] n);
        logic [16:0] mag;
        logic [35:0] prod;
        logic [15:0] q;
        mag  = n[17] ? 17'(-n) : n[16:0];
        prod = 36'(mag) * 36'(DIV3_MAGIC);
        q    = 16'(prod >> DIV3_SHIFT);
        return n[17] ? -q : q;
    endfunction

    function automatic raw_t mk_plain(input cmd_t cmd,
                                      input logic signed [15:0] ex,
                                      input logic signed [15:0] ey);
        raw_t r;
        r     = '0;
        r.cmd = cmd;
        r.ex  = ex;
        r.ey  = ey;
        return r;
    endfunction

    function automatic raw_t mk_curve(input logic signed [15:0] sx,
                                      input logic signed [15:0] sy,
                                      input logic signed [15:0] cx,
                                      input logic signed [15:0] cy,
                                      input logic signed [15:0] ex,
                                      input logic signed [15:0] ey);
        raw_t r;
        r      = '0;
        r.cmd  = CMD_CURVE;
        r.n1x  = twice_plus(cx, sx);
        r.n1y  = twice_plus(cy, sy);
        r.n2x  = twice_plus(cx, ex);
        r.n2y  = twice_plus(cy, ey);
        r.ex   = ex;
        r.ey   = ey;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/qc2c_contour_unit.sv */
`default_nettype none
module qc2c_contour_unit
    import qc2c_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   take,
    input  wire point_t                 pt,
    output raw_t [SLOTS-1:0]            res,
    output logic [SLOT_IDX_W-1:0]       res_cnt
);

    logic               open_reg, open_next;
    logic signed [15:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [15:0] sx_reg, sx_next, sy_reg, sy_next;
    logic               pv_reg, pv_next;
    logic signed [15:0] cx_reg, cx_next, cy_reg, cy_next;

    logic               cend;
    logic               a_vld;
    logic signed [15:0] mx, my;
    raw_t               ra, rc, rf;
    logic [SLOT_IDX_W-1:0] last_idx;

    assign cend = pt.contour_end | pt.glyph_end;

    always_comb begin
        open_next = open_reg;
        fx_next   = fx_reg;
        fy_next   = fy_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        pv_next   = pv_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        a_vld     = 1'b0;
        ra        = '0;
        rc        = '0;
        mx        = mid2(cx_reg, pt.x);
        my        = mid2(cy_reg, pt.y);

        // point itself
        if (!open_reg) begin
            a_vld     = 1'b1;
            ra        = mk_plain(CMD_MOVE, pt.x, pt.y);
            open_next = 1'b1;
            fx_next   = pt.x;
            fy_next   = pt.y;
            sx_next   = pt.x;
            sy_next   = pt.y;
            pv_next   = 1'b0;
        end else if (pt.on_curve) begin
            a_vld = 1'b1;
            if (pv_reg) begin
                ra = mk_curve(sx_reg, sy_reg, cx_reg, cy_reg, pt.x, pt.y);
            end else begin
                ra = mk_plain(CMD_LINE, pt.x, pt.y);
            end
            pv_next = 1'b0;
            sx_next = pt.x;
            sy_next = pt.y;
        end else begin
            // two off-curve points in a row imply an on-curve midpoint
            if (pv_reg) begin
                a_vld   = 1'b1;
                ra      = mk_curve(sx_reg, sy_reg, cx_reg, cy_reg, mx, my);
                sx_next = mx;
                sy_next = my;
            end
            pv_next = 1'b1;
            cx_next = pt.x;
            cy_next = pt.y;
        end

        // close back to the first point
        if (cend) begin
            if (pv_next) begin
                rc = mk_curve(sx_next, sy_next, cx_next, cy_next, fx_next, fy_next);
            end else begin
                rc = mk_plain(CMD_LINE, fx_next, fy_next);
            end
            sx_next   = fx_next;
            sy_next   = fy_next;
            open_next = 1'b0;
            pv_next   = 1'b0;
        end
    end

    assign rf       = mk_plain(CMD_FILL, 16'sd0, 16'sd0);
    assign res_cnt  = {1'b0, a_vld} + {1'b0, cend} + {1'b0, pt.glyph_end};
    assign last_idx = res_cnt - 2'd1;

    always_comb begin
        if (a_vld) begin
            res[0] = ra;
            res[1] = rc;
            res[2] = rf;
        end else begin
            res[0] = rc;
            res[1] = rf;
            res[2] = rf;
        end
        for (int i = 0; i < SLOTS; i++) begin
            res[i].last = (res_cnt != '0) && (last_idx == SLOT_IDX_W'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            pv_reg   <= 1'b0;
            cx_reg   <= '0;
            cy_reg   <= '0;
        end else if (take) begin
            open_reg <= open_next;
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            pv_reg   <= pv_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/qc2c_result_buffer.sv */
`default_nettype none
module qc2c_result_buffer
    import qc2c_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire raw_t [SLOTS-1:0]       load_words,
    input  wire logic [SLOT_IDX_W-1:0]  load_cnt,
    output logic                        free,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_command,
    output logic signed [15:0]          m_ctrl1_x,
    output logic signed [15:0]          m_ctrl1_y,
    output logic signed [15:0]          m_ctrl2_x,
    output logic signed [15:0]          m_ctrl2_y,
    output logic signed [15:0]          m_end_x,
    output logic signed [15:0]          m_end_y,
    output logic                        m_last_of_run
);

    raw_t [SLOTS-1:0]      slot_reg, slot_next;
    logic [SLOT_IDX_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;

    logic               m_valid_reg, m_valid_next;
    cmd_t               m_command_reg, m_command_next;
    logic signed [15:0] m_c1x_reg, m_c1x_next, m_c1y_reg, m_c1y_next;
    logic signed [15:0] m_c2x_reg, m_c2x_next, m_c2y_reg, m_c2y_next;
    logic signed [15:0] m_ex_reg, m_ex_next, m_ey_reg, m_ey_next;
    logic               m_last_reg, m_last_next;

    raw_t head;
    logic out_load;
    logic head_last;

    assign head      = slot_reg[idx_reg];
    assign out_load  = (cnt_reg != '0) && (!m_valid_reg || m_ready);
    assign head_last = (idx_reg == cnt_reg - 2'd1);
    assign free      = (cnt_reg == '0) || (out_load && head_last);

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (load) begin
            slot_next = load_words;
            cnt_next  = load_cnt;
            idx_next  = '0;
        end else if (out_load) begin
            if (head_last) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_command_next = m_command_reg;
        m_c1x_next     = m_c1x_reg;
        m_c1y_next     = m_c1y_reg;
        m_c2x_next     = m_c2x_reg;
        m_c2y_next     = m_c2y_reg;
        m_ex_next      = m_ex_reg;
        m_ey_next      = m_ey_reg;
        m_last_next    = m_last_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_command_next = head.cmd;
            m_c1x_next     = div3(head.n1x);
            m_c1y_next     = div3(head.n1y);
            m_c2x_next     = div3(head.n2x);
            m_c2y_next     = div3(head.n2y);
            m_ex_next      = head.ex;
            m_ey_next      = head.ey;
            m_last_next    = head.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        m_command_reg <= m_command_next;
        m_c1x_reg     <= m_c1x_next;
        m_c1y_reg     <= m_c1y_next;
        m_c2x_reg     <= m_c2x_next;
        m_c2y_reg     <= m_c2y_next;
        m_ex_reg      <= m_ex_next;
        m_ey_reg      <= m_ey_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_command     = m_command_reg;
    assign m_ctrl1_x     = m_c1x_reg;
    assign m_ctrl1_y     = m_c1y_reg;
    assign m_ctrl2_x     = m_c2x_reg;
    assign m_ctrl2_y     = m_c2y_reg;
    assign m_end_x       = m_ex_reg;
    assign m_end_y       = m_ey_reg;
    assign m_last_of_run = m_last_reg;

`include "quadratic_contour_to_cubic_path_assert.svh"

    `QC2C_ASSERT_IMP(a_idx_in_range, aclk, aresetn, cnt_reg != '0, idx_reg < cnt_reg)
    `QC2C_ASSERT_IMP(a_load_when_free, aclk, aresetn, load, free)
    `QC2C_ASSERT_NEXT(a_load_fills, aclk, aresetn, load && load_cnt != '0, cnt_reg != '0)
    `QC2C_ASSERT_IMP(a_fill_is_last, aclk, aresetn, m_valid_reg && m_command_reg == CMD_FILL, m_last_reg && m_ex_reg == '0 && m_ey_reg == '0)
    `QC2C_ASSERT_IMP(a_ctrl_zero, aclk, aresetn, m_valid_reg && m_command_reg != CMD_CURVE, m_c1x_reg == '0 && m_c1y_reg == '0 && m_c2x_reg == '0 && m_c2y_reg == '0)

endmodule
`default_nettype wire

/* rtl/quadratic_contour_to_cubic_path.sv */
// path: a point passes the input register, the result slots and the output register
// throughput: one point per cycle if m_ready is high and each point yields one word;
//   a point of k words (up to 3) holds the result stage, one word a cycle on m_ready
// reset: aresetn synchronous active low, clears contour state and all valid flags
`default_nettype none
module quadratic_contour_to_cubic_path
    import qc2c_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // point input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_point_x,
    input  wire logic signed [15:0] s_point_y,
    input  wire logic               s_on_curve,
    input  wire logic               s_contour_end,
    input  wire logic               s_glyph_end,
    // path command output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_command,
    output logic signed [15:0]      m_ctrl1_x,
    output logic signed [15:0]      m_ctrl1_y,
    output logic signed [15:0]      m_ctrl2_x,
    output logic signed [15:0]      m_ctrl2_y,
    output logic signed [15:0]      m_end_x,
    output logic signed [15:0]      m_end_y,
    output logic                    m_last_of_run
);

    // input register: one point word waiting for the contour logic
    logic   in_vld_reg, in_vld_next;
    point_t in_pt_reg, in_pt_next;

    // handoff into the result slots
    logic                  take;
    logic                  buf_free;
    raw_t [SLOTS-1:0]      words;
    logic [SLOT_IDX_W-1:0] word_cnt;

    // the point moves on as soon as the result slots drain, which may be this very cycle
    assign take    = in_vld_reg && buf_free;
    assign s_ready = !in_vld_reg || take;

    always_comb begin
        in_vld_next = in_vld_reg;
        in_pt_next  = in_pt_reg;
        if (s_valid && s_ready) begin
            in_vld_next          = 1'b1;
            in_pt_next.x           = s_point_x;
            in_pt_next.y           = s_point_y;
            in_pt_next.on_curve    = s_on_curve;
            in_pt_next.contour_end = s_contour_end;
            in_pt_next.glyph_end   = s_glyph_end;
        end else if (take) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_pt_reg <= in_pt_next;
    end

    // contour tracking: move / line / curve / close / fill words, before the divide by three
    qc2c_contour_unit u_contour (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .pt      (in_pt_reg),
        .res     (words),
        .res_cnt (word_cnt)
    );

    // result slots, divide by three for the control points, output register
    qc2c_result_buffer u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (take),
        .load_words    (words),
        .load_cnt      (word_cnt),
        .free          (buf_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_command     (m_command),
        .m_ctrl1_x     (m_ctrl1_x),
        .m_ctrl1_y     (m_ctrl1_y),
        .m_ctrl2_x     (m_ctrl2_x),
        .m_ctrl2_y     (m_ctrl2_y),
        .m_end_x       (m_end_x),
        .m_end_y       (m_end_y),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire
